@@ rtl/core/pcg_pkg.sv @@
// ============================================================================
// pcg_pkg: shared types and constants of the PCG32 generator
// Holds the generator and mixer constants, command codes, controller states
// and the command word that the controller hands to the datapath.
// ============================================================================
package pcg_pkg;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] MIX_K1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_K2   = 64'h94d049bb133111eb;
    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;

    // Mixer phase counter: bit 0 selects the second multiply of a finalizer,
    // bit 1 selects the stream half. The last phase ends the mixing.
    localparam logic [1:0] MIX_PHASE_LAST = 2'd3;

    typedef enum logic [1:0] {
        CMD_DRAW = 2'd0,
        CMD_SEED = 2'd1,
        CMD_MIX  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD,
        DP_MIX_XS,
        DP_MIX_SEED,
        DP_MIX_STREAM,
        DP_SEED_INIT
    } dp_op_t;

    typedef enum logic [1:0] {
        MK_LCG,
        MK_MIX1,
        MK_MIX2
    } mul_kind_t;

    // Partial products of the low 64 bits of a 64 x 64 product.
    typedef enum logic [1:0] {
        MS_LOW,
        MS_CROSS_B,
        MS_CROSS_A
    } mul_step_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW_MUL,
        S_DRAW_PUSH,
        S_MIX_MUL,
        S_MIX_WB,
        S_SEED_INIT,
        S_SEED_MUL
    } fsm_state_t;

    typedef struct packed {
        dp_op_t    op;
        logic      mul_en;
        mul_kind_t kind;
        mul_step_t step;
        logic      load_out;
    } dp_cmd_t;

endpackage

@@ rtl/core/pcg_req_if.sv @@
// ============================================================================
// pcg_req_if: command channel of the PCG32 generator
// Valid/ready channel carrying a command code with its seed and stream words.
// ============================================================================
interface pcg_req_if;

    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] seed_value;
    logic [63:0] stream_value;

    modport source (output valid, output cmd, output seed_value, output stream_value,
                    input ready);
    modport sink (input valid, input cmd, input seed_value, input stream_value,
                  output ready);

endinterface

@@ rtl/core/pcg_word_if.sv @@
// ============================================================================
// pcg_word_if: result channel of the PCG32 generator
// Valid/ready channel carrying one 32-bit random word per beat.
// ============================================================================
interface pcg_word_if;

    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);

endinterface

@@ rtl/core/pcg_datapath.sv @@
// ============================================================================
// pcg_datapath: state, mixer registers and shared multiplier of PCG32
// One 32 x 32 multiplier builds each 64-bit modular product in three steps
// into an accumulator; the controller sequences the steps and write-backs.
// ============================================================================
module pcg_datapath
    import pcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     dp_cmd,
    input  logic [63:0] seed_value,
    input  logic [63:0] stream_value,
    output logic [31:0] random_word
);

    logic [63:0] state_reg,  state_next;
    logic [63:0] inc_reg,    inc_next;
    logic [63:0] acc_reg,    acc_next;
    logic [63:0] x_reg,      x_next;
    logic [63:0] seed_reg,   seed_next;
    logic [63:0] stream_reg, stream_next;
    logic [31:0] word_reg,   word_next;
    logic [31:0] out_reg,    out_next;

    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [63:0] addend;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] product;
    logic [63:0] acc_sum;
    logic [63:0] new_inc;

    // XSH-RR output permutation of a state word.
    function automatic logic [31:0] pcg_output(input logic [63:0] s);
        logic [63:0] t;
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        t   = (s >> 18) ^ s;
        xs  = t[58:27];
        rot = s[63:59];
        dbl = {xs, xs} >> rot;
        return dbl[31:0];
    endfunction

    function automatic logic [63:0] pre_mix(input logic [63:0] v);
        return v ^ (v >> 30);
    endfunction

    always_comb
    begin
        case (dp_cmd.kind)
            MK_MIX1:
            begin
                op_a   = x_reg;
                op_b   = MIX_K1;
                addend = '0;
            end
            MK_MIX2:
            begin
                op_a   = x_reg;
                op_b   = MIX_K2;
                addend = '0;
            end
            default:
            begin
                op_a   = state_reg;
                op_b   = PCG_MULT;
                addend = inc_reg;
            end
        endcase
    end

    always_comb
    begin
        case (dp_cmd.step)
            MS_CROSS_B:
            begin
                mul_x = op_a[31:0];
                mul_y = op_b[63:32];
            end
            MS_CROSS_A:
            begin
                mul_x = op_a[63:32];
                mul_y = op_b[31:0];
            end
            default:
            begin
                mul_x = op_a[31:0];
                mul_y = op_b[31:0];
            end
        endcase
    end

    assign product = 64'(mul_x) * 64'(mul_y);

    // The cross terms only reach the upper half of the truncated product.
    assign acc_sum = (dp_cmd.step == MS_LOW) ? addend + product
                                              : acc_reg + {product[31:0], 32'd0};

    assign new_inc = {stream_reg[62:0], 1'b1};

    always_comb
    begin
        state_next  = state_reg;
        inc_next    = inc_reg;
        acc_next    = acc_reg;
        x_next      = x_reg;
        seed_next   = seed_reg;
        stream_next = stream_reg;
        word_next   = word_reg;
        out_next    = out_reg;

        if (dp_cmd.mul_en)
        begin
            acc_next = acc_sum;
            if (dp_cmd.kind == MK_LCG && dp_cmd.step == MS_CROSS_A)
            begin
                state_next = acc_sum;
            end
        end

        case (dp_cmd.op)
            DP_LOAD:
            begin
                seed_next   = seed_value;
                stream_next = stream_value;
                x_next      = pre_mix(seed_value);
                word_next   = pcg_output(state_reg);
            end
            DP_MIX_XS:
            begin
                x_next = acc_reg ^ (acc_reg >> 27);
            end
            DP_MIX_SEED:
            begin
                // The raw value is still in the seed register at this point.
                seed_next = acc_reg ^ (acc_reg >> 31);
                x_next    = pre_mix(seed_reg ^ GOLDEN);
            end
            DP_MIX_STREAM:
            begin
                stream_next = acc_reg ^ (acc_reg >> 31);
            end
            DP_SEED_INIT:
            begin
                // From a zero state the first step leaves just the increment.
                inc_next   = new_inc;
                state_next = new_inc + seed_reg;
            end
            default:
            begin
            end
        endcase

        if (dp_cmd.load_out)
        begin
            out_next = word_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 64'd0;
            inc_reg   <= 64'd1;
        end
        else
        begin
            state_reg <= state_next;
            inc_reg   <= inc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        seed_reg   <= seed_next;
        stream_reg <= stream_next;
        word_reg   <= word_next;
        out_reg    <= out_next;
    end

    assign random_word = out_reg;

endmodule

@@ rtl/core/pcg_controller.sv @@
// ============================================================================
// pcg_controller: command sequencer of the PCG32 generator
// Accepts commands, steps the shared multiplier and owns the output valid.
// ============================================================================
module pcg_controller
    import pcg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  cmd_t    cmd,
    output logic    in_ready,
    input  logic    out_ready,
    output logic    out_valid,
    output dp_cmd_t dp_cmd
);

    fsm_state_t state_reg, state_next;
    mul_step_t  step_reg,  step_next;
    logic [1:0] mix_reg,   mix_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    function automatic mul_step_t advance(input mul_step_t s);
        case (s)
            MS_LOW:     return MS_CROSS_B;
            MS_CROSS_B: return MS_CROSS_A;
            default:    return MS_LOW;
        endcase
    endfunction

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mix_next   = mix_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        CMD_DRAW:
                        begin
                            state_next = S_DRAW_MUL;
                            step_next  = MS_CROSS_B;
                        end
                        CMD_SEED:
                        begin
                            state_next = S_SEED_INIT;
                        end
                        CMD_MIX:
                        begin
                            state_next = S_MIX_MUL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DRAW_MUL:
            begin
                step_next = advance(step_reg);
                if (step_reg == MS_CROSS_A)
                begin
                    state_next = out_free ? S_IDLE : S_DRAW_PUSH;
                end
            end
            S_DRAW_PUSH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MIX_MUL:
            begin
                step_next = advance(step_reg);
                if (step_reg == MS_CROSS_A)
                begin
                    state_next = S_MIX_WB;
                end
            end
            S_MIX_WB:
            begin
                mix_next   = mix_reg + 2'd1;
                state_next = (mix_reg == MIX_PHASE_LAST) ? S_SEED_INIT : S_MIX_MUL;
            end
            S_SEED_INIT:
            begin
                state_next = S_SEED_MUL;
            end
            S_SEED_MUL:
            begin
                step_next = advance(step_reg);
                if (step_reg == MS_CROSS_A)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                step_next  = MS_LOW;
                mix_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        dp_cmd.op       = DP_NONE;
        dp_cmd.mul_en   = 1'b0;
        dp_cmd.kind     = MK_LCG;
        dp_cmd.step     = step_reg;
        dp_cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.op = DP_LOAD;
                    // A draw starts its multiply in the accept cycle.
                    dp_cmd.mul_en = (cmd == CMD_DRAW);
                end
            end
            S_DRAW_MUL:
            begin
                dp_cmd.mul_en   = 1'b1;
                dp_cmd.load_out = (step_reg == MS_CROSS_A) && out_free;
            end
            S_DRAW_PUSH:
            begin
                dp_cmd.load_out = out_free;
            end
            S_MIX_MUL:
            begin
                dp_cmd.mul_en = 1'b1;
                dp_cmd.kind   = mix_reg[0] ? MK_MIX2 : MK_MIX1;
            end
            S_MIX_WB:
            begin
                if (!mix_reg[0])
                begin
                    dp_cmd.op = DP_MIX_XS;
                end
                else
                begin
                    dp_cmd.op = mix_reg[1] ? DP_MIX_STREAM : DP_MIX_SEED;
                end
            end
            S_SEED_INIT:
            begin
                dp_cmd.op = DP_SEED_INIT;
            end
            S_SEED_MUL:
            begin
                dp_cmd.mul_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = dp_cmd.load_out ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= MS_LOW;
            mix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            mix_reg       <= mix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Counters are back at their start whenever a new command can enter.
    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (step_reg == MS_LOW && mix_reg == '0))
        else $error("step or mix counter not cleared in idle");

    a_draw_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd == CMD_DRAW)
            |=> (state_reg == S_DRAW_MUL && step_reg == MS_CROSS_B))
        else $error("draw did not continue with the cross products");

    a_push_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAW_PUSH) |-> out_valid_reg)
        else $error("waiting to push while the output register is empty");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_out |=> out_valid_reg)
        else $error("loaded word not presented");

    a_mix_to_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX_WB && mix_reg == MIX_PHASE_LAST) |=> (state_reg == S_SEED_INIT))
        else $error("mixing did not hand over to seeding");

endmodule

@@ rtl/core/pcg32_generator_unit.sv @@
// ============================================================================
// pcg32_generator_unit: PCG32 (XSH-RR) random number generator
// Draw, direct seed and mixed seed commands over valid/ready channels.
// ============================================================================
// Usage: each beat on the request channel carries a command. A draw returns
// one 32-bit word on the result channel; a direct seed or a mixed seed
// returns nothing and only reloads the generator. Command code 3 is taken
// and ignored.
// Timing: all 64-bit products are built on one 32 x 32 multiplier in three
// partial-product steps, and that multiplier sets the pace. A draw runs its
// low step in the accept cycle, then its two cross steps, and its word moves
// into the output register once it is free. A direct seed runs the seeding
// step and one product; a mixed seed first runs two splitmix finalizers of
// two products each, then the seeding step. An ignored code starts nothing.
// Reset: the generator state clears to zero and the increment to one, the
// result register empties and the block waits for a command.
// Stalls: the word sits in an output register while the receiver holds
// ready low, and the block keeps accepting seeds. A draw that finishes while
// the previous word is still unread waits until that word is taken.
// ============================================================================
module pcg32_generator_unit
    import pcg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pcg_req_if.sink    request,
    pcg_word_if.source result
);

    dp_cmd_t     dp_cmd;
    logic        ctrl_in_ready;
    logic        ctrl_out_valid;
    logic [31:0] word;

    // Sequencer: owns the handshakes and steps the datapath.
    pcg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .cmd       (cmd_t'(request.cmd)),
        .in_ready  (ctrl_in_ready),
        .out_ready (result.ready),
        .out_valid (ctrl_out_valid),
        .dp_cmd    (dp_cmd)
    );

    // Generator state, mixer registers and the shared multiplier.
    pcg_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .seed_value   (request.seed_value),
        .stream_value (request.stream_value),
        .random_word  (word)
    );

    assign request.ready      = ctrl_in_ready;
    assign result.valid       = ctrl_out_valid;
    assign result.random_word = word;

endmodule
